// ===== rtl/core/q4_block_dequant_dot_product_assert.svh =====
// Assertion helpers shared by the dequant dot-product RTL.
`ifndef Q4_BLOCK_DEQUANT_DOT_PRODUCT_ASSERT_SVH
`define Q4_BLOCK_DEQUANT_DOT_PRODUCT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define Q4_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define Q4_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/q4bdd_pkg.sv =====
`default_nettype none

package q4bdd_pkg;

    localparam int ACT_BITS      = 16;
    localparam int SCALE_BITS    = 32;
    localparam int CODES_BITS    = 48;
    localparam int CODE_BITS     = 6;
    localparam int NUM_CODES     = 8;
    localparam int QBYTE_BITS    = 8;
    localparam int NIB_BITS      = 4;
    localparam int BYTE_POS_BITS = 7;
    localparam int SUB_SHIFT     = 4;   // 16 bytes per sub-block
    localparam int SUB_BITS      = BYTE_POS_BITS - SUB_SHIFT;
    localparam int ACC_BITS      = 64;

    // sub = round(x * code / 31), done as long division by a constant
    localparam int DIV_CONST     = 31;
    localparam int DIV_ROUND     = 15;
    localparam int DIV_REM_BITS  = 5;
    localparam int DIV_DIGIT     = 8;
    localparam int DIV_W         = 40;
    localparam int DIV_STEPS     = DIV_W / DIV_DIGIT;
    localparam int XPROD_BITS    = SCALE_BITS + CODE_BITS + 1;
    localparam int QUOT_BITS     = 34;
    localparam int WGT_BITS      = 39;
    localparam int SPLIT         = 20;

    localparam int QUEUE_DEPTH   = 2;

    localparam logic FUNC_HEADER = 1'b0;
    localparam logic FUNC_DATA   = 1'b1;

    localparam logic [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam logic [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

    typedef struct packed {
        logic                         func;
        logic signed [SCALE_BITS-1:0] block_scale;
        logic signed [SCALE_BITS-1:0] block_min;
        logic [CODES_BITS-1:0]        scale_codes;
        logic [QBYTE_BITS-1:0]        quant_byte;
        logic signed [ACT_BITS-1:0]   act_even;
        logic signed [ACT_BITS-1:0]   act_odd;
        logic                         last_of_row;
    } t_request;

    typedef struct packed {
        logic signed [ACC_BITS-1:0] row_sum;
        logic                       saturated;
    } t_result;

    // One data item with the header context it was classified under
    typedef struct packed {
        logic signed [SCALE_BITS-1:0] scale;
        logic signed [SCALE_BITS-1:0] min;
        logic [CODE_BITS-1:0]         code;
        logic [QBYTE_BITS-1:0]        qbyte;
        logic signed [ACT_BITS-1:0]   act_even;
        logic signed [ACT_BITS-1:0]   act_odd;
        logic                         last;
    } t_work;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_WGT,
        BK_MUL,
        BK_SUM,
        BK_ACC_EVEN,
        BK_ACC_ODD
    } t_back_state;

endpackage

`default_nettype wire

// ===== rtl/core/q4bdd_front.sv =====
`default_nettype none
`include "q4_block_dequant_dot_product_assert.svh"

module q4bdd_front (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_req_valid,
    output logic                          o_req_ready,
    input  wire q4bdd_pkg::t_request      i_req,
    input  wire q4bdd_pkg::t_queue_status i_q_status,
    output logic                          o_push,
    output q4bdd_pkg::t_work              o_work
);

    logic signed [q4bdd_pkg::SCALE_BITS-1:0] r_scale;
    logic signed [q4bdd_pkg::SCALE_BITS-1:0] r_min;
    logic [q4bdd_pkg::CODES_BITS-1:0]        r_codes;
    logic [q4bdd_pkg::BYTE_POS_BITS-1:0]     r_byte_pos;
    logic [q4bdd_pkg::SUB_BITS-1:0]          sub;
    logic                                    accept;

    assign o_req_ready = !i_q_status.full;
    assign accept      = i_req_valid && o_req_ready;
    assign o_push      = accept && (i_req.func == q4bdd_pkg::FUNC_DATA);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale    <= '0;
            r_min      <= '0;
            r_codes    <= '0;
            r_byte_pos <= '0;
        end else if (accept) begin
            if (i_req.func == q4bdd_pkg::FUNC_HEADER) begin
                r_scale    <= i_req.block_scale;
                r_min      <= i_req.block_min;
                r_codes    <= i_req.scale_codes;
                r_byte_pos <= '0;
            end else begin
                // wraps after 128 bytes
                r_byte_pos <= r_byte_pos + 1'b1;
            end
        end
    end

    always_comb begin
        sub             = r_byte_pos[q4bdd_pkg::BYTE_POS_BITS-1:q4bdd_pkg::SUB_SHIFT];
        o_work.scale    = r_scale;
        o_work.min      = r_min;
        o_work.code     = r_codes[sub*q4bdd_pkg::CODE_BITS +: q4bdd_pkg::CODE_BITS];
        o_work.qbyte    = i_req.quant_byte;
        o_work.act_even = i_req.act_even;
        o_work.act_odd  = i_req.act_odd;
        o_work.last     = i_req.last_of_row;
    end

    `Q4_ASSERT_NEXT(a_hdr_clears_pos, i_clk, i_rst_n, accept && (i_req.func == q4bdd_pkg::FUNC_HEADER), r_byte_pos == '0, "header did not restart byte position")

endmodule

`default_nettype wire

// ===== rtl/core/q4bdd_queue.sv =====
`default_nettype none
`include "q4_block_dequant_dot_product_assert.svh"

module q4bdd_queue #(
    parameter int DEPTH = q4bdd_pkg::QUEUE_DEPTH
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_push,
    input  wire q4bdd_pkg::t_work    i_work,
    input  wire                      i_pop,
    output q4bdd_pkg::t_work         o_head,
    output q4bdd_pkg::t_queue_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    q4bdd_pkg::t_work  r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

    `Q4_ASSERT_IMPLY(a_no_overflow, i_clk, i_rst_n, i_push, !o_status.full, "push into full queue")
    `Q4_ASSERT_IMPLY(a_no_underflow, i_clk, i_rst_n, i_pop, !o_status.empty, "pop from empty queue")
    `Q4_ASSERT_NEXT(a_count_track, i_clk, i_rst_n, 1'b1, r_count == $past(r_count) + CNT_W'($past(i_push)) - CNT_W'($past(i_pop)), "queue count out of step")

endmodule

`default_nettype wire

// ===== rtl/core/q4bdd_back.sv =====
`default_nettype none

module q4bdd_back (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire q4bdd_pkg::t_work         i_head,
    input  wire q4bdd_pkg::t_queue_status i_q_status,
    output logic                          o_pop,
    output logic                          o_res_valid,
    input  wire                           i_res_ready,
    output q4bdd_pkg::t_result            o_res
);

    localparam int AB     = q4bdd_pkg::ACT_BITS;
    localparam int WB     = q4bdd_pkg::WGT_BITS;
    localparam int SP     = q4bdd_pkg::SPLIT;
    localparam int XB     = q4bdd_pkg::XPROD_BITS;
    localparam int DW     = q4bdd_pkg::DIV_W;
    localparam int DG     = q4bdd_pkg::DIV_DIGIT;
    localparam int RB     = q4bdd_pkg::DIV_REM_BITS;
    localparam int QB     = q4bdd_pkg::QUOT_BITS;
    localparam int NB     = q4bdd_pkg::NIB_BITS;
    localparam int AW     = q4bdd_pkg::ACC_BITS;
    localparam int PL_W   = SP + 1 + AB;
    localparam int PH_W   = WB - SP + AB;
    localparam int PW     = WB + AB;
    localparam int SW     = (PW > AW + 1) ? PW : AW + 1;
    localparam int STEP_W = $clog2(q4bdd_pkg::DIV_STEPS);

    // one radix-256 digit of division by 31
    function automatic logic [RB+DG-1:0] div_digit(input logic [RB-1:0] rem,
                                                   input logic [DG-1:0] bits);
        logic [RB:0]    t;
        logic [RB-1:0]  r;
        logic [DG-1:0]  q;
        r = rem;
        q = '0;
        for (int i = DG - 1; i >= 0; i--) begin
            t = {r, bits[i]};
            if (t >= (RB+1)'(q4bdd_pkg::DIV_CONST)) begin
                q[i] = 1'b1;
                t    = t - (RB+1)'(q4bdd_pkg::DIV_CONST);
            end
            r = t[RB-1:0];
        end
        return {r, q};
    endfunction

    // clip a full product to 64 bits; -2^63 itself also counts as a clip
    function automatic logic [AW:0] sat_prod(input logic signed [SW-1:0] p);
        logic [SW-AW:0] top;
        logic           all_one;
        logic           all_zero;
        top      = p[SW-1:AW-1];
        all_one  = &top;
        all_zero = ~|top;
        if (!all_one && !all_zero) begin
            return {1'b1, p[SW-1] ? q4bdd_pkg::ACC_MIN : q4bdd_pkg::ACC_MAX};
        end
        return {all_one && (p[AW-2:0] == '0), p[AW-1:0]};
    endfunction

    function automatic logic [AW:0] sat_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {a[AW-1], a} + {b[AW-1], b};
        if (s[AW] != s[AW-1]) begin
            return {1'b1, s[AW] ? q4bdd_pkg::ACC_MIN : q4bdd_pkg::ACC_MAX};
        end
        return {1'b0, s[AW-1:0]};
    endfunction

    q4bdd_pkg::t_back_state r_state, n_state;
    q4bdd_pkg::t_work       r_work;

    logic                    r_neg_s, r_neg_m;
    logic [DW-1:0]           r_div_s, r_div_m;
    logic [DW-1:0]           r_quo_s, r_quo_m;
    logic [RB-1:0]           r_rem_s, r_rem_m;
    logic [STEP_W-1:0]       r_step;
    logic signed [WB-1:0]    r_w_even, r_w_odd;
    logic signed [PL_W-1:0]  r_pl_even, r_pl_odd;
    logic signed [PH_W-1:0]  r_ph_even, r_ph_odd;
    logic [AW-1:0]           r_p_even, r_p_odd;
    logic [AW-1:0]           r_acc;
    logic                    r_clip;
    logic                    r_out_valid;
    q4bdd_pkg::t_result      r_out;

    logic signed [XB-1:0]    x_s, x_m;
    logic [XB-1:0]           mag_s, mag_m;
    logic [RB+DG-1:0]        dig_s, dig_m;
    logic signed [WB-1:0]    ss, sm;
    logic signed [QB-1:0]    q_s, q_m;
    logic signed [PW-1:0]    p_even, p_odd;
    logic [AW:0]             sp_even, sp_odd;
    logic [AW:0]             sum;
    logic                    out_take;
    logic                    out_free;
    logic                    out_load;

    assign out_take = r_out_valid && i_res_ready;
    assign out_free = !r_out_valid || i_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= q4bdd_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        out_load = 1'b0;
        case (r_state)
            q4bdd_pkg::BK_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop   = 1'b1;
                    n_state = q4bdd_pkg::BK_DIV;
                end
            end
            q4bdd_pkg::BK_DIV: begin
                if (r_step == STEP_W'(q4bdd_pkg::DIV_STEPS - 1)) begin
                    n_state = q4bdd_pkg::BK_WGT;
                end
            end
            q4bdd_pkg::BK_WGT:      n_state = q4bdd_pkg::BK_MUL;
            q4bdd_pkg::BK_MUL:      n_state = q4bdd_pkg::BK_SUM;
            q4bdd_pkg::BK_SUM:      n_state = q4bdd_pkg::BK_ACC_EVEN;
            q4bdd_pkg::BK_ACC_EVEN: n_state = q4bdd_pkg::BK_ACC_ODD;
            q4bdd_pkg::BK_ACC_ODD: begin
                // a row end waits for the result register
                if (!r_work.last || out_free) begin
                    out_load = r_work.last;
                    n_state  = q4bdd_pkg::BK_IDLE;
                end
            end
            default: n_state = q4bdd_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        x_s   = i_head.scale * $signed({1'b0, i_head.code});
        x_m   = i_head.min * $signed({1'b0, i_head.code});
        mag_s = x_s[XB-1] ? -x_s : x_s;
        mag_m = x_m[XB-1] ? -x_m : x_m;
        dig_s = div_digit(r_rem_s, r_div_s[DW-1 -: DG]);
        dig_m = div_digit(r_rem_m, r_div_m[DW-1 -: DG]);
        q_s   = $signed({1'b0, r_quo_s[QB-2:0]});
        q_m   = $signed({1'b0, r_quo_m[QB-2:0]});
        ss    = WB'(r_neg_s ? -q_s : q_s);
        sm    = WB'(r_neg_m ? -q_m : q_m);
        p_even = (PW'(r_ph_even) <<< SP) + PW'(r_pl_even);
        p_odd  = (PW'(r_ph_odd) <<< SP) + PW'(r_pl_odd);
        sp_even = sat_prod(SW'(p_even));
        sp_odd  = sat_prod(SW'(p_odd));
        sum = sat_add(r_acc, (r_state == q4bdd_pkg::BK_ACC_EVEN) ? r_p_even : r_p_odd);
    end

    // datapath payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            q4bdd_pkg::BK_IDLE: begin
                r_work  <= i_head;
                r_neg_s <= x_s[XB-1];
                r_neg_m <= x_m[XB-1];
                r_div_s <= DW'(mag_s) + DW'(q4bdd_pkg::DIV_ROUND);
                r_div_m <= DW'(mag_m) + DW'(q4bdd_pkg::DIV_ROUND);
                r_quo_s <= '0;
                r_quo_m <= '0;
                r_rem_s <= '0;
                r_rem_m <= '0;
                r_step  <= '0;
            end
            q4bdd_pkg::BK_DIV: begin
                r_div_s <= r_div_s << DG;
                r_div_m <= r_div_m << DG;
                r_quo_s <= {r_quo_s[DW-DG-1:0], dig_s[DG-1:0]};
                r_quo_m <= {r_quo_m[DW-DG-1:0], dig_m[DG-1:0]};
                r_rem_s <= dig_s[RB+DG-1:DG];
                r_rem_m <= dig_m[RB+DG-1:DG];
                r_step  <= r_step + 1'b1;
            end
            q4bdd_pkg::BK_WGT: begin
                r_w_even <= ss * $signed({1'b0, r_work.qbyte[NB-1:0]}) + sm;
                r_w_odd  <= ss * $signed({1'b0, r_work.qbyte[2*NB-1:NB]}) + sm;
            end
            q4bdd_pkg::BK_MUL: begin
                r_pl_even <= $signed({1'b0, r_w_even[SP-1:0]}) * r_work.act_even;
                r_ph_even <= $signed(r_w_even[WB-1:SP]) * r_work.act_even;
                r_pl_odd  <= $signed({1'b0, r_w_odd[SP-1:0]}) * r_work.act_odd;
                r_ph_odd  <= $signed(r_w_odd[WB-1:SP]) * r_work.act_odd;
            end
            q4bdd_pkg::BK_SUM: begin
                r_p_even <= sp_even[AW-1:0];
                r_p_odd  <= sp_odd[AW-1:0];
            end
            default: begin
            end
        endcase
        if (out_load) begin
            r_out.row_sum   <= sum[AW-1:0];
            r_out.saturated <= r_clip || sum[AW];
        end
    end

    // accumulator, row clip flag and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_clip      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == q4bdd_pkg::BK_SUM) begin
                r_clip <= r_clip || sp_even[AW] || sp_odd[AW];
            end else if (r_state == q4bdd_pkg::BK_ACC_EVEN) begin
                r_acc  <= sum[AW-1:0];
                r_clip <= r_clip || sum[AW];
            end else if (r_state == q4bdd_pkg::BK_ACC_ODD && n_state == q4bdd_pkg::BK_IDLE) begin
                r_acc  <= out_load ? '0 : sum[AW-1:0];
                r_clip <= out_load ? 1'b0 : (r_clip || sum[AW]);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

`default_nettype wire

// ===== rtl/core/q4_block_dequant_dot_product.sv =====
// Sequence: a row-ending request accepted into an idle block passes the queue-to-back load,
// 5 divide-by-31 digit steps, weight, multiply, combine and two saturating adds before its
// result shows.
// Flow: the shared back-end sequence finishes one data request before it pops the next; headers
// stay in the front and overlap with back-end work. A held result stalls the back at a row end.
// Reset: synchronous active low; clears header registers, byte position, accumulator,
// clip flag, queue and result valid.
`default_nettype none

module q4_block_dequant_dot_product #(
    parameter int QUEUE_DEPTH = q4bdd_pkg::QUEUE_DEPTH
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_req_valid,
    output logic                     o_req_ready,
    input  wire q4bdd_pkg::t_request i_req,
    output logic                     o_res_valid,
    input  wire                      i_res_ready,
    output q4bdd_pkg::t_result       o_res
);

    q4bdd_pkg::t_queue_status q_status;
    q4bdd_pkg::t_work         push_work;
    q4bdd_pkg::t_work         head_work;
    logic                     push;
    logic                     pop;

    q4bdd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_work      (push_work)
    );

    q4bdd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_work   (push_work),
        .i_pop    (pop),
        .o_head   (head_work),
        .o_status (q_status)
    );

    q4bdd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_work),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES  = 200_000;
    localparam int DRAIN_CYCLES  = 64;
    localparam int PHASE_REQS    = 140;
    localparam int PHASE_ROWS    = 3;
    localparam int REQ_BITS      = $bits(q4bdd_pkg::t_request);
    localparam int IDLE_PCT  [4] = '{0, 71, 0, 33};
    localparam int STALL_PCT [4] = '{0, 0, 71, 33};

    // Tracks header registers, byte position and accumulator; queues row sums.
    class row_sum_predictor;
        logic signed [q4bdd_pkg::SCALE_BITS-1:0] hdr_scale;
        logic signed [q4bdd_pkg::SCALE_BITS-1:0] hdr_min;
        logic [q4bdd_pkg::CODES_BITS-1:0]        hdr_codes;
        logic [q4bdd_pkg::BYTE_POS_BITS-1:0]     byte_pos;
        logic signed [q4bdd_pkg::ACC_BITS-1:0]   acc;
        bit                                      clip;
        q4bdd_pkg::t_result                      sums_due[$];
        int                                      errors;
        int                                      n_requests;
        int                                      n_rows;

        function new();
            hdr_scale  = '0;
            hdr_min    = '0;
            hdr_codes  = '0;
            byte_pos   = '0;
            acc        = '0;
            clip       = 1'b0;
            errors     = 0;
            n_requests = 0;
            n_rows     = 0;
        endfunction

        // round to nearest; a quotient by 31 is never a tie
        function longint div31_round(longint x);
            if (x >= 0)
                return (x + 15) / 31;
            return -((-x + 15) / 31);
        endfunction

        // -2^63 has no positive counterpart and counts as a clip
        function logic signed [q4bdd_pkg::ACC_BITS-1:0] clip_product(longint w, longint a);
            logic signed [127:0] p;
            p = w;
            p = p * a;
            if (p[127:63] != {65{p[127]}} || (p[127] && p[62:0] == '0)) begin
                clip = 1'b1;
                return p[127] ? q4bdd_pkg::ACC_MIN : q4bdd_pkg::ACC_MAX;
            end
            return p[63:0];
        endfunction

        function void add_to_acc(logic signed [q4bdd_pkg::ACC_BITS-1:0] x);
            logic signed [q4bdd_pkg::ACC_BITS:0] s;
            s = acc + x;
            if (s[q4bdd_pkg::ACC_BITS] != s[q4bdd_pkg::ACC_BITS-1]) begin
                clip = 1'b1;
                acc  = s[q4bdd_pkg::ACC_BITS] ? q4bdd_pkg::ACC_MIN : q4bdd_pkg::ACC_MAX;
            end else begin
                acc = s[q4bdd_pkg::ACC_BITS-1:0];
            end
        endfunction

        function void note_request(q4bdd_pkg::t_request r);
            int                 sub;
            longint             code;
            longint             seg_scale;
            longint             seg_min;
            longint             w_even;
            longint             w_odd;
            q4bdd_pkg::t_result e;
            n_requests++;
            if (r.func == q4bdd_pkg::FUNC_HEADER) begin
                hdr_scale = r.block_scale;
                hdr_min   = r.block_min;
                hdr_codes = r.scale_codes;
                byte_pos  = '0;
                return;
            end
            sub       = byte_pos >> q4bdd_pkg::SUB_SHIFT;
            code      = hdr_codes[sub*q4bdd_pkg::CODE_BITS +: q4bdd_pkg::CODE_BITS];
            seg_scale = div31_round(longint'(hdr_scale) * code);
            seg_min   = div31_round(longint'(hdr_min) * code);
            w_even    = longint'(r.quant_byte[3:0]) * seg_scale + seg_min;
            w_odd     = longint'(r.quant_byte[7:4]) * seg_scale + seg_min;
            add_to_acc(clip_product(w_even, longint'(r.act_even)));
            add_to_acc(clip_product(w_odd, longint'(r.act_odd)));
            byte_pos++;
            if (!r.last_of_row)
                return;
            e.row_sum   = acc;
            e.saturated = clip;
            sums_due.push_back(e);
            acc  = '0;
            clip = 1'b0;
            n_rows++;
        endfunction

        task report(string what);
            if (errors < 50)
                $display("mismatch: %s", what);
            errors++;
        endtask

        task check_result(q4bdd_pkg::t_result got);
            q4bdd_pkg::t_result want;
            if (sums_due.size() == 0) begin
                report($sformatf("row sum %0d with no row pending", got.row_sum));
                return;
            end
            want = sums_due.pop_front();
            if (got.row_sum !== want.row_sum)
                report($sformatf("row_sum %0d, want %0d", got.row_sum, want.row_sum));
            if (got.saturated !== want.saturated)
                report($sformatf("saturated %0b, want %0b", got.saturated, want.saturated));
        endtask
    endclass

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_req_valid = 1'b0;
    q4bdd_pkg::t_request i_req       = '0;
    logic                i_res_ready = 1'b0;
    logic                o_req_ready;
    logic                o_res_valid;
    q4bdd_pkg::t_result  o_res;

    int idle_pct  = 0;
    int stall_pct = 0;
    int cycles    = 0;

    row_sum_predictor sb = new();

    q4_block_dequant_dot_product dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && i_res_ready)
            sb.check_result(o_res);
        i_res_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic q4bdd_pkg::t_request random_req();
        logic [159:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
        return q4bdd_pkg::t_request'(bits[REQ_BITS-1:0]);
    endfunction

    // unused fields carry random bits
    function automatic q4bdd_pkg::t_request header_req(logic [31:0] scale, logic [31:0] min_val,
                                                       logic [47:0] codes, logic last);
        q4bdd_pkg::t_request r;
        r = random_req();
        r.func        = q4bdd_pkg::FUNC_HEADER;
        r.block_scale = scale;
        r.block_min   = min_val;
        r.scale_codes = codes;
        r.last_of_row = last;
        return r;
    endfunction

    function automatic q4bdd_pkg::t_request data_req(logic [7:0] qb, logic [15:0] ae,
                                                     logic [15:0] ao, logic last);
        q4bdd_pkg::t_request r;
        r = random_req();
        r.func        = q4bdd_pkg::FUNC_DATA;
        r.quant_byte  = qb;
        r.act_even    = ae;
        r.act_odd     = ao;
        r.last_of_row = last;
        return r;
    endfunction

    function automatic logic [31:0] pick32();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3: return $urandom_range(32'h0002_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick16();
        case ($urandom_range(9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return '0;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [47:0] pick_codes();
        case ($urandom_range(7))
            0: return '1;
            1: return '0;
            default: return 48'({$urandom, $urandom});
        endcase
    endfunction

    task automatic send(input q4bdd_pkg::t_request r);
        while ($urandom_range(99) < idle_pct) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= r;
        do @(posedge i_clk); while (!o_req_ready);
        sb.note_request(r);
    endtask

    task automatic wait_rows_drained();
        i_req_valid <= 1'b0;
        do @(posedge i_clk); while (sb.sums_due.size() != 0);
    endtask

    // mostly header plus short, full or wrapping blocks; rows may span blocks
    // or continue the previous block without a new header
    task automatic random_row();
        int nblocks;
        int len;
        bit skip_header;
        bit last;
        skip_header = ($urandom_range(3) == 0);
        nblocks     = ($urandom_range(4) == 0) ? 2 : 1;
        for (int b = 0; b < nblocks; b++) begin
            if (!(b == 0 && skip_header))
                send(header_req(pick32(), pick32(), pick_codes(), 1'($urandom_range(1))));
            case ($urandom_range(19))
                0, 1: len = 128;
                2:    len = $urandom_range(129, 150);
                default: len = $urandom_range(1, 16);
            endcase
            for (int k = 0; k < len; k++) begin
                last = (b == nblocks - 1) && (k == len - 1);
                if (!last && $urandom_range(39) == 0)
                    send(random_req());
                send(data_req(8'($urandom_range(255)), pick16(), pick16(), last));
            end
        end
    endtask

    initial begin
        while (cycles < LIMIT_CYCLES)
            @(posedge i_clk);
        $display("testbench: done, errors");
        $finish;
    end

    initial begin
        int first_req;
        int first_row;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // data before any header: zero weights
        send(data_req(8'hFF, 16'h7FFF, 16'h8000, 1'b1));
        // header's last bit is ignored
        send(header_req(32'h7FFF_FFFF, 32'h8000_0000, '1, 1'b1));
        send(data_req(8'hFF, 16'h7FFF, 16'h8000, 1'b0));
        send(data_req(8'h00, 16'h8000, 16'h7FFF, 1'b0));
        send(data_req(8'h0F, 16'h8000, 16'h8000, 1'b1));
        // row ends mid-block, next row keeps counting positions
        send(data_req(8'hF0, 16'h7FFF, 16'h7FFF, 1'b1));
        send(header_req(32'h8000_0000, 32'h7FFF_FFFF,
                        {6'd21, 6'd63, 6'd62, 6'd32, 6'd31, 6'd30, 6'd1, 6'd0}, 1'b0));
        send(data_req(8'hA5, 16'h1234, 16'hFFFF, 1'b0));
        // new block in the middle of a row
        send(header_req(32'h0001_0000, 32'hFFFF_0000, {8{6'd31}}, 1'b0));
        send(data_req(8'h3C, 16'h1000, 16'h1000, 1'b0));
        send(data_req(8'hC3, 16'hF000, 16'h0001, 1'b1));
        send(header_req('0, '0, '0, 1'b1));
        send(data_req(8'h5A, 16'h7FFF, 16'h7FFF, 1'b0));
        send(data_req(8'hFF, 16'h8000, 16'h8000, 1'b1));
        wait_rows_drained();

        for (int phase = 0; phase < 4; phase++) begin
            idle_pct  = IDLE_PCT[phase];
            stall_pct = STALL_PCT[phase];
            first_req = sb.n_requests;
            first_row = sb.n_rows;
            while (sb.n_requests - first_req < PHASE_REQS ||
                   sb.n_rows - first_row < PHASE_ROWS)
                random_row();
            wait_rows_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/q4bdd_pkg.sv
rtl/core/q4bdd_front.sv
rtl/core/q4bdd_queue.sv
rtl/core/q4bdd_back.sv
rtl/core/q4_block_dequant_dot_product.sv
sim/testbench.sv
